### hdl/bged_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bged_pkg
// Shared types and constants for the button gesture event decoder.
// ----------------------------------------------------------------------------
package bged_pkg;

   localparam int TIME_W  = 32;
   localparam int CFG_W   = 16;
   localparam int INDEX_W = 2;
   localparam int EVENT_W = 3;

   typedef logic [TIME_W-1:0]  time_type;
   typedef logic [CFG_W-1:0]   cfg_type;
   typedef logic [INDEX_W-1:0] index_type;
   typedef logic [EVENT_W-1:0] event_type;

   localparam index_type REG_DEBOUNCE      = 2'd0;
   localparam index_type REG_LONG_PRESS    = 2'd1;
   localparam index_type REG_DOUBLE_WINDOW = 2'd2;

   localparam cfg_type DEBOUNCE_RESET      = 16'd50;
   localparam cfg_type LONG_PRESS_RESET    = 16'd800;
   localparam cfg_type DOUBLE_WINDOW_RESET = 16'd400;

   localparam event_type EV_NONE   = 3'd0;
   localparam event_type EV_PREV   = 3'd1;
   localparam event_type EV_NEXT   = 3'd2;
   localparam event_type EV_UP     = 3'd3;
   localparam event_type EV_DOWN   = 3'd4;
   localparam event_type EV_SINGLE = 3'd5;
   localparam event_type EV_DOUBLE = 3'd6;
   localparam event_type EV_LONG   = 3'd7;

   typedef enum logic [2:0] {
      GS_IDLE  = 3'd0,
      GS_HELD1 = 3'd1,
      GS_LONG  = 3'd2,
      GS_WAIT  = 3'd3,
      GS_HELD2 = 3'd4
   } gesture_state_type;

endpackage

### hdl/button_gesture_event_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_gesture_event_decoder
// Decodes one poll of five button levels and a millisecond timestamp into
// one event: prev, next, volume up/down with auto-repeat, or a single,
// double or long press of play.
// ----------------------------------------------------------------------------
// Each accepted request yields exactly one response, via the input register
// and then the result register; a new request can be accepted every cycle
// while the response side is not stalled. The debounce compares and the play
// gesture state update are done in one pass of logic that loads the result
// register and the decoder state at the same edge, so the next request
// already sees the updated state. A stalled response holds the result
// register; one more request waits in the input register. The user must
// write the three timing registers through the csr port only while no request
// is in flight, not enforced here; only indexes 0 to 2 exist, others ignored.
module button_gesture_event_decoder (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  bged_pkg::time_type      req_now_ms,
   input  logic                    req_prev_pressed,
   input  logic                    req_next_pressed,
   input  logic                    req_vol_up_pressed,
   input  logic                    req_vol_down_pressed,
   input  logic                    req_play_pressed,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output bged_pkg::event_type     rsp_event_code,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  bged_pkg::index_type     csr_index,
   input  bged_pkg::cfg_type       csr_wdata
);
   import bged_pkg::*;

   cfg_type           debounce_ff, long_press_ff, double_window_ff;

   logic              s1_valid_ff;
   time_type          now_ff;
   logic              prev_ff, next_ff, up_ff, down_ff, play_ff;

   logic              rsp_valid_ff;
   event_type         event_ff, event_in;

   time_type          prev_last_ff, next_last_ff, up_last_ff, down_last_ff;
   time_type          entered_ff, trans_ff;
   gesture_state_type gesture_ff, gesture_in;

   logic              advance;
   logic              prev_fire, next_fire, up_fire, down_fire, any_fire;
   logic              deb_ok, long_hit, window_hit;
   time_type          deb_limit;
   event_type         play_event;
   logic              trans_upd, entered_upd;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_event_code = event_ff;

   // debounce compares for the simple buttons
   assign deb_limit = {{(TIME_W-CFG_W){1'b0}}, debounce_ff};
   assign prev_fire = prev_ff && ((now_ff - prev_last_ff) > deb_limit);
   assign next_fire = next_ff && ((now_ff - next_last_ff) > deb_limit);
   assign up_fire   = up_ff   && ((now_ff - up_last_ff)   > deb_limit);
   assign down_fire = down_ff && ((now_ff - down_last_ff) > deb_limit);
   assign any_fire  = prev_fire || next_fire || up_fire || down_fire;

   assign deb_ok     = (now_ff - trans_ff) > deb_limit;
   assign long_hit   = (now_ff - entered_ff) >=
                       {{(TIME_W-CFG_W){1'b0}}, long_press_ff};
   assign window_hit = (now_ff - entered_ff) >=
                       {{(TIME_W-CFG_W){1'b0}}, double_window_ff};

   // play gesture next state
   always_comb begin
      gesture_in = gesture_ff;
      case (gesture_ff)
         GS_HELD1, GS_HELD2: begin
            if (play_ff) begin
               if (long_hit) gesture_in = GS_LONG;
            end else if (deb_ok) begin
               gesture_in = (gesture_ff == GS_HELD1) ? GS_WAIT : GS_IDLE;
            end
         end
         GS_LONG: begin
            if (!play_ff && deb_ok) gesture_in = GS_IDLE;
         end
         GS_WAIT: begin
            if (play_ff && deb_ok) gesture_in = GS_HELD2;
            else if (!play_ff && window_hit) gesture_in = GS_IDLE;
         end
         default: begin
            if (play_ff && deb_ok) gesture_in = GS_HELD1;
         end
      endcase
   end

   // play gesture outputs
   always_comb begin
      play_event  = EV_NONE;
      trans_upd   = 1'b0;
      entered_upd = 1'b0;
      case (gesture_ff)
         GS_HELD1, GS_HELD2: begin
            if (play_ff) begin
               if (long_hit) begin
                  trans_upd  = 1'b1;
                  play_event = EV_LONG;
               end
            end else if (deb_ok) begin
               trans_upd = 1'b1;
               if (gesture_ff == GS_HELD1) entered_upd = 1'b1;
               else play_event = EV_DOUBLE;
            end
         end
         GS_LONG: begin
            if (!play_ff && deb_ok) trans_upd = 1'b1;
         end
         GS_WAIT: begin
            if (play_ff && deb_ok) begin
               trans_upd   = 1'b1;
               entered_upd = 1'b1;
            end else if (!play_ff && window_hit) begin
               play_event = EV_SINGLE;
            end
         end
         default: begin
            if (play_ff && deb_ok) begin
               trans_upd   = 1'b1;
               entered_upd = 1'b1;
            end
         end
      endcase
   end

   always_comb begin
      if (prev_fire)      event_in = EV_PREV;
      else if (next_fire) event_in = EV_NEXT;
      else if (up_fire)   event_in = EV_UP;
      else if (down_fire) event_in = EV_DOWN;
      else                event_in = play_event;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff      <= DEBOUNCE_RESET;
         long_press_ff    <= LONG_PRESS_RESET;
         double_window_ff <= DOUBLE_WINDOW_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            REG_DEBOUNCE:      debounce_ff      <= csr_wdata;
            REG_LONG_PRESS:    long_press_ff    <= csr_wdata;
            REG_DOUBLE_WINDOW: double_window_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         now_ff  <= req_now_ms;
         prev_ff <= req_prev_pressed;
         next_ff <= req_next_pressed;
         up_ff   <= req_vol_up_pressed;
         down_ff <= req_vol_down_pressed;
         play_ff <= req_play_pressed;
      end
   end

   // result register and decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         prev_last_ff <= '0;
         next_last_ff <= '0;
         up_last_ff   <= '0;
         down_last_ff <= '0;
         entered_ff   <= '0;
         trans_ff     <= '0;
         gesture_ff   <= GS_IDLE;
      end else begin
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (advance) begin
            if (prev_fire) begin
               prev_last_ff <= now_ff;
            end else if (next_fire) begin
               next_last_ff <= now_ff;
            end else if (up_fire) begin
               up_last_ff <= now_ff;
            end else if (down_fire) begin
               down_last_ff <= now_ff;
            end
            if (!any_fire) begin
               gesture_ff <= gesture_in;
               if (trans_upd)   trans_ff   <= now_ff;
               if (entered_upd) entered_ff <= now_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         event_ff <= event_in;
      end
   end

endmodule

### hdl/bged_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bged_checker
// Port-level checks for the button gesture event decoder, bound to the top.
// ----------------------------------------------------------------------------
module bged_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input bged_pkg::event_type rsp_event_code
);
   import bged_pkg::*;

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_code))
      else $error("stalled response changed");

   // no response right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

   // a drained output never blocks requests
   a_no_block: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("request blocked while output drains");

   // an accepted request is answered via the input and result registers without stall
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) ##1 rsp_ready |=> rsp_valid)
      else $error("request not answered");

endmodule

bind button_gesture_event_decoder bged_checker u_bged_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_event_code (rsp_event_code)
);

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the button gesture event decoder. A queue-fed
// driver offers polls in bursts, a monitor stalls the response side and
// checks every event code against a cycle-free model of the debounce,
// auto-repeat and play gesture logic. Runs directed polls, then random
// button sequences under several timing register settings.
// ----------------------------------------------------------------------------
module tb;
   import bged_pkg::*;

   localparam index_type REG_UNUSED = 2'd3;

   typedef struct packed {
      time_type now_ms;
      logic     prev_pressed;
      logic     next_pressed;
      logic     up_pressed;
      logic     down_pressed;
      logic     play_pressed;
   } button_poll_type;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_ready;
   time_type  req_now_ms = '0;
   logic      req_prev_pressed = 1'b0;
   logic      req_next_pressed = 1'b0;
   logic      req_vol_up_pressed = 1'b0;
   logic      req_vol_down_pressed = 1'b0;
   logic      req_play_pressed = 1'b0;
   logic      rsp_valid;
   logic      rsp_ready = 1'b0;
   event_type rsp_event_code;
   logic      csr_valid = 1'b0;
   logic      csr_ready;
   index_type csr_index = REG_DEBOUNCE;
   cfg_type   csr_wdata = '0;

   // model copy of the timing registers and decoder state
   cfg_type           debounce_cfg = DEBOUNCE_RESET;
   cfg_type           long_press_cfg = LONG_PRESS_RESET;
   cfg_type           window_cfg = DOUBLE_WINDOW_RESET;
   time_type          prev_fired_at = '0;
   time_type          next_fired_at = '0;
   time_type          up_fired_at = '0;
   time_type          down_fired_at = '0;
   gesture_state_type gesture = GS_IDLE;
   time_type          gesture_entered_at = '0;
   time_type          gesture_moved_at = '0;

   button_poll_type pending_polls[$];
   event_type       expected_events[$];
   button_poll_type poll_on_bus;
   int           failure_count = 0;
   int           burst_left = 0;
   int           gap_left = 0;
   int           ready_run_left = 0;
   int           ready_stall_left = 0;
   int           long_stall_left = 0;
   logic         offer_now;
   logic         ready_now;
   logic         no_gaps = 1'b0;
   logic         hold_rsp = 1'b0;
   logic         hold_taken = 1'b0;
   event_type    want_event;
   time_type     stim_ms = '0;
   logic         play_level = 1'b0;

   button_gesture_event_decoder dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_now_ms           (req_now_ms),
      .req_prev_pressed     (req_prev_pressed),
      .req_next_pressed     (req_next_pressed),
      .req_vol_up_pressed   (req_vol_up_pressed),
      .req_vol_down_pressed (req_vol_down_pressed),
      .req_play_pressed     (req_play_pressed),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_event_code       (rsp_event_code),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic event_type decode_poll(button_poll_type p);
      time_type since_prev;
      time_type since_next;
      time_type since_up;
      time_type since_down;
      time_type since_move;
      time_type since_entry;
      time_type deb_w;
      time_type long_w;
      time_type window_w;
      logic     settled;
      deb_w       = time_type'(debounce_cfg);
      long_w      = time_type'(long_press_cfg);
      window_w    = time_type'(window_cfg);
      since_prev  = p.now_ms - prev_fired_at;
      since_next  = p.now_ms - next_fired_at;
      since_up    = p.now_ms - up_fired_at;
      since_down  = p.now_ms - down_fired_at;
      since_move  = p.now_ms - gesture_moved_at;
      since_entry = p.now_ms - gesture_entered_at;
      settled     = since_move > deb_w;
      if (p.prev_pressed && since_prev > deb_w) begin
         prev_fired_at = p.now_ms;
         return EV_PREV;
      end
      if (p.next_pressed && since_next > deb_w) begin
         next_fired_at = p.now_ms;
         return EV_NEXT;
      end
      if (p.up_pressed && since_up > deb_w) begin
         up_fired_at = p.now_ms;
         return EV_UP;
      end
      if (p.down_pressed && since_down > deb_w) begin
         down_fired_at = p.now_ms;
         return EV_DOWN;
      end
      case (gesture)
         GS_HELD1, GS_HELD2: begin
            if (p.play_pressed) begin
               if (since_entry >= long_w) begin
                  gesture_moved_at = p.now_ms;
                  gesture = GS_LONG;
                  return EV_LONG;
               end
            end else if (settled) begin
               gesture_moved_at = p.now_ms;
               if (gesture == GS_HELD1) begin
                  gesture = GS_WAIT;
                  gesture_entered_at = p.now_ms;
               end else begin
                  gesture = GS_IDLE;
                  return EV_DOUBLE;
               end
            end
         end
         GS_LONG: begin
            if (!p.play_pressed && settled) begin
               gesture_moved_at = p.now_ms;
               gesture = GS_IDLE;
            end
         end
         GS_WAIT: begin
            if (p.play_pressed && settled) begin
               gesture_moved_at = p.now_ms;
               gesture = GS_HELD2;
               gesture_entered_at = p.now_ms;
            end else if (!p.play_pressed && since_entry >= window_w) begin
               gesture = GS_IDLE;
               return EV_SINGLE;
            end
         end
         default: begin
            if (p.play_pressed && settled) begin
               gesture_moved_at = p.now_ms;
               gesture = GS_HELD1;
               gesture_entered_at = p.now_ms;
            end
         end
      endcase
      return EV_NONE;
   endfunction

   task automatic note_failure(string msg);
      failure_count++;
      if (failure_count <= 10)
         $display("mismatch at %0t: %s", $time, msg);
   endtask

   // buttons: {prev, next, vol up, vol down, play}
   task automatic add_poll(time_type at_ms, logic [4:0] buttons);
      button_poll_type p;
      p.now_ms = at_ms;
      {p.prev_pressed, p.next_pressed, p.up_pressed, p.down_pressed,
       p.play_pressed} = buttons;
      pending_polls.push_back(p);
      stim_ms = at_ms;
   endtask

   task automatic queue_random_polls(int count);
      button_poll_type p;
      int unsigned  span;
      int unsigned  step;
      span = 32'(debounce_cfg);
      if (32'(long_press_cfg) > span)
         span = 32'(long_press_cfg);
      if (32'(window_cfg) > span)
         span = 32'(window_cfg);
      span = span + 8;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 15))
            0: step = $urandom;
            1, 2, 3: step = $urandom_range(0, 3);
            default: step = $urandom_range(0, span);
         endcase
         stim_ms = stim_ms + step;
         if ($urandom_range(0, 2) == 0)
            play_level = !play_level;
         p.now_ms       = stim_ms;
         p.prev_pressed = ($urandom_range(0, 11) == 0);
         p.next_pressed = ($urandom_range(0, 11) == 0);
         p.up_pressed   = ($urandom_range(0, 11) == 0);
         p.down_pressed = ($urandom_range(0, 11) == 0);
         p.play_pressed = play_level;
         // noise: any button combination
         if ($urandom_range(0, 15) == 0)
            {p.prev_pressed, p.next_pressed, p.up_pressed, p.down_pressed,
             p.play_pressed} = 5'($urandom);
         pending_polls.push_back(p);
      end
   endtask

   task automatic write_reg(index_type idx, cfg_type data);
      csr_index <= idx;
      csr_wdata <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_DEBOUNCE:      debounce_cfg = data;
         REG_LONG_PRESS:    long_press_cfg = data;
         REG_DOUBLE_WINDOW: window_cfg = data;
         default: ;
      endcase
   endtask

   task automatic wait_until_drained();
      do @(negedge clock);
      while (pending_polls.size() != 0 || req_valid || expected_events.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            expected_events.push_back(decode_poll(poll_on_bus));
         if (!req_valid || req_ready) begin
            offer_now = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_polls.size() > 0) begin
               poll_on_bus = pending_polls.pop_front();
               req_now_ms           <= poll_on_bus.now_ms;
               req_prev_pressed     <= poll_on_bus.prev_pressed;
               req_next_pressed     <= poll_on_bus.next_pressed;
               req_vol_up_pressed   <= poll_on_bus.up_pressed;
               req_vol_down_pressed <= poll_on_bus.down_pressed;
               req_play_pressed     <= poll_on_bus.play_pressed;
               offer_now = 1'b1;
               if (burst_left == 0)
                  burst_left = $urandom_range(1, 24);
               burst_left--;
               if (burst_left == 0 && !no_gaps)
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
            req_valid <= offer_now;
         end
      end
   end

   // response monitor and stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_events.size() == 0) begin
               note_failure($sformatf("unexpected response event_code=%0d",
                                      rsp_event_code));
            end else begin
               want_event = expected_events.pop_front();
               if (rsp_event_code !== want_event)
                  note_failure($sformatf("event_code expected %0d got %0d",
                                         want_event, rsp_event_code));
            end
         end
         // long hold-off while requests keep coming
         if (hold_rsp && !hold_taken) begin
            hold_taken      = 1'b1;
            long_stall_left = 300;
         end
         if (long_stall_left > 0) begin
            long_stall_left--;
            ready_now = 1'b0;
         end else if (ready_run_left > 0) begin
            ready_run_left--;
            ready_now = 1'b1;
         end else if (ready_stall_left > 0) begin
            ready_stall_left--;
            ready_now = 1'b0;
         end else begin
            ready_run_left   = $urandom_range(1, 40);
            ready_stall_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            ready_now = 1'b1;
         end
         rsp_ready <= ready_now;
      end
   end

   initial begin
      #6_000_000;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      cfg_type db;
      cfg_type lp;
      cfg_type dw;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset timing: debounce 50, long press 800, window 400
      add_poll(32'd0,    5'b10000);   // debounce not passed at time zero
      add_poll(32'd51,   5'b11111);
      add_poll(32'd51,   5'b01111);
      add_poll(32'd51,   5'b00111);
      add_poll(32'd51,   5'b00011);
      add_poll(32'd51,   5'b00001);
      add_poll(32'd101,  5'b10001);   // exactly debounce, no repeat
      add_poll(32'd102,  5'b10001);   // auto-repeat
      add_poll(32'd851,  5'b00001);   // long press at exact hold time
      add_poll(32'd860,  5'b00000);
      add_poll(32'd902,  5'b00000);
      add_poll(32'd953,  5'b00001);
      add_poll(32'd1004, 5'b00000);
      add_poll(32'd1030, 5'b00001);   // press during wait, debounce fails
      add_poll(32'd1404, 5'b00000);   // window expires, single
      add_poll(32'd1460, 5'b00001);
      add_poll(32'd1511, 5'b00000);
      add_poll(32'd1910, 5'b00000);
      add_poll(32'd1911, 5'b00001);
      add_poll(32'd1962, 5'b00000);   // double
      add_poll(32'd2013, 5'b00001);
      add_poll(32'd2064, 5'b00000);
      add_poll(32'd2115, 5'b00001);
      add_poll(32'd2915, 5'b00001);   // long second press drops first tap
      add_poll(32'd2966, 5'b00000);
      add_poll(32'hFFFF_FFF0, 5'b10000);
      add_poll(32'h0000_0030, 5'b10000);   // time wraps
      wait_until_drained();

      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: begin db = DEBOUNCE_RESET; lp = LONG_PRESS_RESET; dw = DOUBLE_WINDOW_RESET; end
            1: begin db = 16'd0; lp = 16'd0; dw = 16'd0; end
            2: begin db = 16'hFFFF; lp = 16'hFFFF; dw = 16'hFFFF; end
            3: begin db = 16'd10; lp = 16'd200; dw = 16'd100; end
            4: begin db = 16'd0; lp = 16'hFFFF; dw = 16'd0; end
            5: begin db = 16'hFFFF; lp = 16'd0; dw = 16'hFFFF; end
            6: begin
               db = cfg_type'($urandom_range(0, 300));
               lp = cfg_type'($urandom_range(0, 300));
               dw = cfg_type'($urandom_range(0, 300));
            end
            default: begin
               db = cfg_type'($urandom_range(0, 65535));
               lp = cfg_type'($urandom_range(0, 65535));
               dw = cfg_type'($urandom_range(0, 65535));
            end
         endcase
         @(posedge clock);
         write_reg(REG_DEBOUNCE, db);
         if (ph == 1)
            write_reg(REG_UNUSED, cfg_type'($urandom));
         write_reg(REG_LONG_PRESS, lp);
         write_reg(REG_DOUBLE_WINDOW, dw);
         csr_valid <= 1'b0;

         for (int chunk = 0; chunk < 2; chunk++) begin
            // receiver holds off while requests keep coming
            if (ph == 3 && chunk == 0) begin
               @(posedge clock);
               hold_rsp <= 1'b1;
               no_gaps  <= 1'b1;
            end
            queue_random_polls(62);
            if (ph == 3 && chunk == 0) begin
               do @(negedge clock); while (!hold_taken || long_stall_left != 0);
               hold_rsp <= 1'b0;
               no_gaps  <= 1'b0;
            end
            wait_until_drained();
         end
      end

      if (failure_count == 0 && expected_events.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

### files.f
hdl/bged_pkg.sv
hdl/button_gesture_event_decoder.sv
hdl/bged_checker.sv
tb/sv/tb.sv
